// File: hdl/assert_macros.svh
// Assertion macros for the tokenizer RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define SLT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent.
`define SLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/slt_pkg.sv
// Shared types and constants of the shell line tokenizer.
// No dependencies; used by slt_step, slt_result_queue and the top level.
package slt_pkg;

  // Characters with a meaning to the scanner
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  typedef enum logic [3:0] {
    MODE_START   = 4'd0,
    MODE_BLANK   = 4'd1,
    MODE_WORD    = 4'd2,
    MODE_REDIR   = 4'd3,
    MODE_SQUOTE  = 4'd4,
    MODE_DQUOTE  = 4'd5,
    MODE_DISCARD = 4'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_ENDTOK  = 2'd1,
    KIND_ENDLINE = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_CHAR    = 3'd0,
    ERR_REDIR_FIRST = 3'd1,
    ERR_REDIR_END   = 3'd2,
    ERR_AFTER_REDIR = 3'd3,
    ERR_GT_GAP      = 3'd4,
    ERR_GT_MANY     = 3'd5,
    ERR_OPEN_QUOTE  = 3'd6
  } err_t;

  typedef struct packed {
    mode_t      mode;
    logic       escape_pending;
    logic       prev_was_gt;
    logic [1:0] gt_run;
  } scan_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] token_byte;
    logic       special;
    err_t       error_code;
    logic       last;
  } result_t;

  // Handoff from the scanner to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: hdl/slt_step.sv
// Next-state and result logic of the tokenizer for one input byte.
// Depends on slt_pkg.
module slt_step (
  input  slt_pkg::scan_state_t cur,
  input  logic [7:0]           line_byte,
  output slt_pkg::scan_state_t nxt,
  output slt_pkg::push_t       push
);

  logic          fail_en;
  slt_pkg::err_t fail_code;
  logic          is_redir;
  logic          is_plain;
  logic          is_nl;

  assign is_nl    = (line_byte == slt_pkg::CH_NL);
  assign is_redir = (line_byte == slt_pkg::CH_LT) || (line_byte == slt_pkg::CH_GT) ||
                    (line_byte == slt_pkg::CH_PIPE);
  assign is_plain = (line_byte >= slt_pkg::CH_SPACE) && (line_byte <= slt_pkg::CH_DEL);

  always_comb begin
    nxt       = cur;
    push      = '0;
    fail_en   = 1'b0;
    fail_code = slt_pkg::ERR_BAD_CHAR;

    unique case (cur.mode)
      slt_pkg::MODE_DISCARD: begin
        if (is_nl) nxt.mode = slt_pkg::MODE_START;
      end

      slt_pkg::MODE_WORD: begin
        if (is_nl) begin
          push.count       = 2'd2;
          push.first.kind  = slt_pkg::KIND_ENDTOK;
          push.second.kind = slt_pkg::KIND_ENDLINE;
          nxt.mode         = slt_pkg::MODE_START;
        end else if (line_byte == slt_pkg::CH_DQ) begin
          nxt.mode = slt_pkg::MODE_DQUOTE;
        end else if (line_byte == slt_pkg::CH_SQ) begin
          nxt.mode = slt_pkg::MODE_SQUOTE;
        end else if (is_redir) begin
          // close the word, open a redirect token
          push.count              = 2'd2;
          push.first.kind         = slt_pkg::KIND_ENDTOK;
          push.second.kind        = slt_pkg::KIND_BYTE;
          push.second.token_byte  = line_byte;
          push.second.special     = 1'b1;
          nxt.mode                = slt_pkg::MODE_REDIR;
          nxt.prev_was_gt         = (line_byte == slt_pkg::CH_GT);
          nxt.gt_run              = {1'b0, (line_byte == slt_pkg::CH_GT)};
        end else if (line_byte == slt_pkg::CH_SPACE) begin
          push.count      = 2'd1;
          push.first.kind = slt_pkg::KIND_ENDTOK;
          nxt.mode        = slt_pkg::MODE_BLANK;
        end else if (is_plain) begin
          push.count            = 2'd1;
          push.first.kind       = slt_pkg::KIND_BYTE;
          push.first.token_byte = line_byte;
        end else begin
          fail_en = 1'b1;
        end
      end

      slt_pkg::MODE_REDIR: begin
        if ((line_byte == slt_pkg::CH_DQ) || (line_byte == slt_pkg::CH_SQ)) begin
          push.count         = 2'd1;
          push.first.kind    = slt_pkg::KIND_ENDTOK;
          push.first.special = 1'b1;
          nxt.mode           = (line_byte == slt_pkg::CH_DQ) ? slt_pkg::MODE_DQUOTE
                                                             : slt_pkg::MODE_SQUOTE;
          nxt.escape_pending = 1'b0;
          nxt.prev_was_gt    = 1'b0;
          nxt.gt_run         = 2'd0;
        end else if (is_nl) begin
          fail_en   = 1'b1;
          fail_code = slt_pkg::ERR_REDIR_END;
        end else if ((line_byte == slt_pkg::CH_LT) || (line_byte == slt_pkg::CH_PIPE)) begin
          fail_en   = 1'b1;
          fail_code = slt_pkg::ERR_AFTER_REDIR;
        end else if (line_byte == slt_pkg::CH_GT) begin
          // extend > to >>, only with no gap and at most two
          if (!cur.prev_was_gt) begin
            fail_en   = 1'b1;
            fail_code = slt_pkg::ERR_GT_GAP;
          end else if (cur.gt_run >= 2'd2) begin
            fail_en   = 1'b1;
            fail_code = slt_pkg::ERR_GT_MANY;
          end else begin
            push.count            = 2'd1;
            push.first.kind       = slt_pkg::KIND_BYTE;
            push.first.token_byte = line_byte;
            push.first.special    = 1'b1;
            nxt.gt_run            = cur.gt_run + 2'd1;
          end
        end else if (line_byte == slt_pkg::CH_SPACE) begin
          nxt.prev_was_gt = 1'b0;
        end else if (is_plain) begin
          push.count             = 2'd2;
          push.first.kind        = slt_pkg::KIND_ENDTOK;
          push.first.special     = 1'b1;
          push.second.kind       = slt_pkg::KIND_BYTE;
          push.second.token_byte = line_byte;
          nxt.mode               = slt_pkg::MODE_WORD;
          nxt.escape_pending     = 1'b0;
          nxt.prev_was_gt        = 1'b0;
          nxt.gt_run             = 2'd0;
        end else begin
          fail_en = 1'b1;
        end
      end

      slt_pkg::MODE_SQUOTE, slt_pkg::MODE_DQUOTE: begin
        if (cur.escape_pending) begin
          nxt.escape_pending = 1'b0;
          if (is_nl) begin
            fail_en   = 1'b1;
            fail_code = slt_pkg::ERR_OPEN_QUOTE;
          end else begin
            push.count            = 2'd1;
            push.first.kind       = slt_pkg::KIND_BYTE;
            push.first.token_byte = line_byte;
          end
        end else if (((cur.mode == slt_pkg::MODE_SQUOTE) && (line_byte == slt_pkg::CH_SQ)) ||
                     ((cur.mode == slt_pkg::MODE_DQUOTE) && (line_byte == slt_pkg::CH_DQ))) begin
          nxt.mode = slt_pkg::MODE_WORD;
        end else if (is_nl) begin
          fail_en   = 1'b1;
          fail_code = slt_pkg::ERR_OPEN_QUOTE;
        end else if (line_byte == slt_pkg::CH_BSL) begin
          nxt.escape_pending = 1'b1;
        end else begin
          push.count            = 2'd1;
          push.first.kind       = slt_pkg::KIND_BYTE;
          push.first.token_byte = line_byte;
        end
      end

      default: begin
        // line start and after blank
        if (is_nl) begin
          push.count         = 2'd1;
          push.first.kind    = slt_pkg::KIND_ENDLINE;
          nxt.mode           = slt_pkg::MODE_START;
          nxt.escape_pending = 1'b0;
          nxt.prev_was_gt    = 1'b0;
          nxt.gt_run         = 2'd0;
        end else if ((line_byte == slt_pkg::CH_DQ) || (line_byte == slt_pkg::CH_SQ)) begin
          nxt.mode           = (line_byte == slt_pkg::CH_DQ) ? slt_pkg::MODE_DQUOTE
                                                             : slt_pkg::MODE_SQUOTE;
          nxt.escape_pending = 1'b0;
          nxt.prev_was_gt    = 1'b0;
          nxt.gt_run         = 2'd0;
        end else if (is_redir) begin
          if (cur.mode == slt_pkg::MODE_BLANK) begin
            push.count            = 2'd1;
            push.first.kind       = slt_pkg::KIND_BYTE;
            push.first.token_byte = line_byte;
            push.first.special    = 1'b1;
            nxt.mode              = slt_pkg::MODE_REDIR;
            nxt.escape_pending    = 1'b0;
            nxt.prev_was_gt       = (line_byte == slt_pkg::CH_GT);
            nxt.gt_run            = {1'b0, (line_byte == slt_pkg::CH_GT)};
          end else begin
            fail_en   = 1'b1;
            fail_code = slt_pkg::ERR_REDIR_FIRST;
          end
        end else if (line_byte == slt_pkg::CH_SPACE) begin
          if (cur.mode != slt_pkg::MODE_BLANK) nxt.mode = slt_pkg::MODE_START;
          nxt.escape_pending = 1'b0;
          nxt.prev_was_gt    = 1'b0;
          nxt.gt_run         = 2'd0;
        end else if (is_plain) begin
          push.count            = 2'd1;
          push.first.kind       = slt_pkg::KIND_BYTE;
          push.first.token_byte = line_byte;
          nxt.mode              = slt_pkg::MODE_WORD;
          nxt.escape_pending    = 1'b0;
          nxt.prev_was_gt       = 1'b0;
          nxt.gt_run            = 2'd0;
        end else begin
          fail_en = 1'b1;
        end
      end
    endcase

    // Replace everything with one error result and drop to discard, or to line start on a newline
    if (fail_en) begin
      push               = '0;
      push.count         = 2'd1;
      push.first.kind    = slt_pkg::KIND_ERROR;
      push.first.error_code = fail_code;
      nxt.mode           = is_nl ? slt_pkg::MODE_START : slt_pkg::MODE_DISCARD;
      nxt.escape_pending = 1'b0;
      nxt.prev_was_gt    = 1'b0;
      nxt.gt_run         = 2'd0;
    end

    // Mark the final result of this byte
    if (push.count == 2'd1) push.first.last  = 1'b1;
    if (push.count == 2'd2) push.second.last = 1'b1;
  end

endmodule

// File: hdl/slt_result_queue.sv
// Four-entry result queue between the scanner and the output stream.
// Takes up to two results per cycle, gives one per cycle. Depends on slt_pkg.
module slt_result_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_en,
  input  slt_pkg::push_t            push,
  input  logic                      pop,
  output logic                      not_empty,
  output logic                      room2,
  output slt_pkg::result_t          head,
  output logic [slt_pkg::QCW-1:0]   level
);

  slt_pkg::result_t              slots [slt_pkg::QDEPTH];
  logic [slt_pkg::QAW-1:0]       wr_ptr;
  logic [slt_pkg::QAW-1:0]       rd_ptr;
  logic [slt_pkg::QCW-1:0]       level_next;
  logic [1:0]                    push_cnt;

  assign push_cnt   = push_en ? push.count : 2'd0;
  assign level_next = level + {1'b0, push_cnt} - {{(slt_pkg::QCW-1){1'b0}}, pop};
  assign not_empty  = (level != '0);
  assign room2      = (level <= slt_pkg::QCW'(slt_pkg::QDEPTH - 2));
  assign head       = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + slt_pkg::QAW'(push_cnt);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      level <= level_next;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) slots[wr_ptr] <= push.first;
    if (push_cnt == 2'd2) slots[wr_ptr + 1'b1] <= push.second;
  end

endmodule

// File: hdl/shell_line_tokenizer_unit.sv
// Shell command line tokenizer: top level with scan state and stream ports.
// Depends on slt_pkg, slt_step, slt_result_queue and assert_macros.svh.
//
// Takes one line byte per transfer and streams out token bytes, end-of-token,
// end-of-line and error results. A byte is taken in the cycle it is offered
// whenever the four-entry result queue has two free slots, so bytes enter at
// one per clock; the output leaves at one result per clock while m_tready is
// high, so a byte that gives two results (a token end plus a byte, or a token
// end plus line end) takes two output transfers, and the sustained rate is one
// byte per clock while results average at most one per byte. A byte's results
// are registered in the result queue before they reach the output port.
// Discarded bytes after an error give no result.
`include "assert_macros.svh"

module shell_line_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] line_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] token_byte, [10:8] error_code, [15:11] zero
  output logic [2:0]  m_tuser,   // [1:0] kind, [2] special
  output logic        m_tlast
);

  slt_pkg::scan_state_t          state;
  slt_pkg::scan_state_t          state_next;
  slt_pkg::push_t                push;
  slt_pkg::result_t              head;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          room2;
  logic [slt_pkg::QCW-1:0]       level;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = room2;

  slt_step u_step (
    .cur       (state),
    .line_byte (s_tdata),
    .nxt       (state_next),
    .push      (push)
  );

  slt_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (in_xfer),
    .push      (push),
    .pop       (out_xfer),
    .not_empty (m_tvalid),
    .room2     (room2),
    .head      (head),
    .level     (level)
  );

  // Hold scan state; advance on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode           <= slt_pkg::MODE_START;
      state.escape_pending <= 1'b0;
      state.prev_was_gt    <= 1'b0;
      state.gt_run         <= 2'd0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Pack the head result onto the output stream
  assign m_tdata = {5'd0, head.error_code, head.token_byte};
  assign m_tuser = {head.special, head.kind};
  assign m_tlast = head.last;

  `SLT_ASSERT(a_level_bound, level <= slt_pkg::QCW'(slt_pkg::QDEPTH), "result queue overfilled")
  `SLT_ASSERT_IMPL(a_discard_silent, in_xfer && (state.mode == slt_pkg::MODE_DISCARD), push.count == 2'd0, "discarded byte produced a result")
  `SLT_ASSERT_IMPL(a_pair_last, push.count == 2'd2, !push.first.last && push.second.last, "last flag misplaced in result pair")
  `SLT_ASSERT_NEXT(a_push_visible, in_xfer && (push.count != 2'd0), m_tvalid, "pushed result not offered")

endmodule
